[src/assert_macros.svh]
// Assertion helpers included by difficulty_p_adjust.sv.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The consequent must hold whenever the antecedent holds at a clock edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`endif

`endif

[src/dpa_pkg.sv]
package dpa_pkg;

    // Field and datapath widths.
    localparam int REG_W      = 32;
    localparam int WORD_W     = 64;
    localparam int DIFF_W     = 256;
    localparam int PROD_W     = DIFF_W + REG_W;
    localparam int LIMBS      = DIFF_W / REG_W;
    localparam int CFG_IDX_W  = 3;

    // Long division steps, one quotient bit per stage.
    localparam int DIV1_STEPS = 2 * REG_W;
    localparam int DIV2_STEPS = PROD_W;

    // Smallest difficulty that the block ever reports.
    localparam logic [DIFF_W-1:0] DIFF_FLOOR = DIFF_W'(2);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN         = 3'd0,
        CFG_SET_POINT    = 3'd1,
        CFG_ADJUST_MIN   = 3'd2,
        CFG_ADJUST_MAX   = 3'd3,
        CFG_QUANTIZATION = 3'd4
    } cfg_idx_t;

endpackage

[src/difficulty_p_adjust.sv]
// Proportional difficulty adjustment.
// Command channel: an item (measurement and the four parent words) is taken
// at each rising edge where start is high and busy is low. busy stays low,
// so a new item may enter in every cycle.
// Result channel: done is high for exactly one cycle while next_word0..3
// hold the new difficulty. The receiver cannot stall, and none is needed:
// the pipeline always advances.
// Throughput is one item per cycle. Most of the pipeline is made up of two
// bit-serial long dividers laid out as pipeline stages: 64 stages for the
// timing-error quotient and 288 stages for the scaled delta, plus entry,
// multiply, clamp and final add/saturate stages.
// Configuration: cfg_we writes cfg_data into register cfg_index at the same
// edge; indexes past the register list are ignored. Registers must only be
// changed while no item is in flight.
// Reset clears all stage valid bits and restores the register defaults
// (gain 5, set point 60, limits -5 and 5, quantization 10).
module difficulty_p_adjust (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   measurement,
    input  logic [63:0]                   parent_word0,
    input  logic [63:0]                   parent_word1,
    input  logic [63:0]                   parent_word2,
    input  logic [63:0]                   parent_word3,
    output logic                          done,
    output logic [63:0]                   next_word0,
    output logic [63:0]                   next_word1,
    output logic [63:0]                   next_word2,
    output logic [63:0]                   next_word3,
    input  logic                          cfg_we,
    input  logic [dpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpa_pkg::REG_W-1:0]     cfg_data
);
    import dpa_pkg::*;

`include "assert_macros.svh"

    localparam int LAT = 2 + DIV1_STEPS + 4 + DIV2_STEPS + 3;

    // Configuration registers.
    logic [REG_W-1:0] gain_reg;
    logic [REG_W-1:0] set_point_reg;
    logic [REG_W-1:0] adjust_min_reg;
    logic [REG_W-1:0] adjust_max_reg;
    logic [REG_W-1:0] quantization_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg         <= REG_W'(5);
            set_point_reg    <= REG_W'(60);
            adjust_min_reg   <= REG_W'(-5);
            adjust_max_reg   <= REG_W'(5);
            quantization_reg <= REG_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN:         gain_reg         <= cfg_data;
                CFG_SET_POINT:    set_point_reg    <= cfg_data;
                CFG_ADJUST_MIN:   adjust_min_reg   <= cfg_data;
                CFG_ADJUST_MAX:   adjust_max_reg   <= cfg_data;
                CFG_QUANTIZATION: quantization_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // A zero divisor is treated as one.
    logic [REG_W-1:0] sp_div;
    logic [REG_W-1:0] qd_div;
    assign sp_div = (set_point_reg == '0) ? REG_W'(1) : set_point_reg;
    assign qd_div = (quantization_reg == '0) ? REG_W'(1) : quantization_reg;

    assign busy = 1'b0;

    // Entry stage: magnitudes and sign of gain and timing error.
    logic              s0_v_reg;
    logic [REG_W-1:0]  s0_gm_reg;
    logic [REG_W-1:0]  s0_dm_reg;
    logic              s0_neg_reg;
    logic [DIFF_W-1:0] s0_par_reg;
    logic [REG_W:0]    err_next;
    logic [REG_W:0]    err_mag;

    assign err_next = {1'b0, set_point_reg} - {1'b0, measurement};
    assign err_mag  = err_next[REG_W] ? ((REG_W+1)'(0) - err_next) : err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_gm_reg  <= gain_reg[REG_W-1] ? (REG_W'(0) - gain_reg) : gain_reg;
        s0_dm_reg  <= err_mag[REG_W-1:0];
        s0_neg_reg <= gain_reg[REG_W-1] ^ err_next[REG_W];
        s0_par_reg <= {parent_word3, parent_word2, parent_word1, parent_word0};
    end

    // Gain times error magnitude.
    logic                s1_v_reg;
    logic [2*REG_W-1:0]  s1_prod_reg;
    logic                s1_neg_reg;
    logic [DIFF_W-1:0]   s1_par_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= (2*REG_W)'(s0_gm_reg) * (2*REG_W)'(s0_dm_reg);
        s1_neg_reg  <= s0_neg_reg;
        s1_par_reg  <= s0_par_reg;
    end

    // First divider: product / set point, one quotient bit per stage.
    logic               d1_v_reg   [DIV1_STEPS];
    logic [2*REG_W-1:0] d1_num_reg [DIV1_STEPS];
    logic [REG_W-1:0]   d1_rem_reg [DIV1_STEPS];
    logic               d1_neg_reg [DIV1_STEPS];
    logic [DIFF_W-1:0]  d1_par_reg [DIV1_STEPS];

    for (genvar k = 0; k < DIV1_STEPS; k++)
    begin : g_div1
        logic               v_in;
        logic [2*REG_W-1:0] num_in;
        logic [REG_W-1:0]   rem_in;
        logic               neg_in;
        logic [DIFF_W-1:0]  par_in;
        logic [REG_W:0]     trial;
        logic [REG_W:0]     sub;
        logic               ge;

        if (k == 0)
        begin : g_first
            assign v_in   = s1_v_reg;
            assign num_in = s1_prod_reg;
            assign rem_in = '0;
            assign neg_in = s1_neg_reg;
            assign par_in = s1_par_reg;
        end
        else
        begin : g_rest
            assign v_in   = d1_v_reg[k-1];
            assign num_in = d1_num_reg[k-1];
            assign rem_in = d1_rem_reg[k-1];
            assign neg_in = d1_neg_reg[k-1];
            assign par_in = d1_par_reg[k-1];
        end

        assign trial = {rem_in, num_in[2*REG_W-1]};
        assign sub   = trial - {1'b0, sp_div};
        assign ge    = (trial >= {1'b0, sp_div});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d1_v_reg[k] <= 1'b0;
            end
            else
            begin
                d1_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            d1_rem_reg[k] <= ge ? sub[REG_W-1:0] : trial[REG_W-1:0];
            d1_num_reg[k] <= {num_in[2*REG_W-2:0], ge};
            d1_neg_reg[k] <= neg_in;
            d1_par_reg[k] <= par_in;
        end
    end

    // Clamp to the upper limit, then to the lower limit.
    logic              c1_v_reg;
    logic [REG_W-1:0]  c1_adj_reg;
    logic [DIFF_W-1:0] c1_par_reg;
    logic [2*REG_W:0]  adj_wide;
    logic [2*REG_W:0]  hi_wide;
    logic [2*REG_W:0]  lo_wide;
    logic [2*REG_W:0]  adj_hi;
    logic [2*REG_W:0]  adj_clamp;
    logic [REG_W-1:0]  adj_next;

    always_comb
    begin
        adj_wide = {1'b0, d1_num_reg[DIV1_STEPS-1]};
        if (d1_neg_reg[DIV1_STEPS-1])
        begin
            adj_wide = (2*REG_W+1)'(0) - adj_wide;
        end
        hi_wide   = {{(REG_W+1){adjust_max_reg[REG_W-1]}}, adjust_max_reg};
        lo_wide   = {{(REG_W+1){adjust_min_reg[REG_W-1]}}, adjust_min_reg};
        adj_hi    = ($signed(adj_wide) > $signed(hi_wide)) ? hi_wide : adj_wide;
        adj_clamp = ($signed(adj_hi) < $signed(lo_wide)) ? lo_wide : adj_hi;
        adj_next  = adj_clamp[REG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_v_reg <= 1'b0;
        end
        else
        begin
            c1_v_reg <= d1_v_reg[DIV1_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        c1_adj_reg <= adj_next;
        c1_par_reg <= d1_par_reg[DIV1_STEPS-1];
    end

    // Adjustment magnitude and sign.
    logic              c2_v_reg;
    logic [REG_W-1:0]  c2_am_reg;
    logic              c2_neg_reg;
    logic              c2_nz_reg;
    logic [DIFF_W-1:0] c2_par_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_v_reg <= 1'b0;
        end
        else
        begin
            c2_v_reg <= c1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c2_am_reg  <= c1_adj_reg[REG_W-1] ? (REG_W'(0) - c1_adj_reg) : c1_adj_reg;
        c2_neg_reg <= c1_adj_reg[REG_W-1];
        c2_nz_reg  <= |c1_adj_reg;
        c2_par_reg <= c1_par_reg;
    end

    // Partial products of each 32-bit parent limb with the magnitude.
    logic              m1_v_reg;
    logic [2*REG_W-1:0] m1_pp_reg [LIMBS];
    logic              m1_neg_reg;
    logic              m1_nz_reg;
    logic [DIFF_W-1:0] m1_par_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
        end
        else
        begin
            m1_v_reg <= c2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            m1_pp_reg[i] <= (2*REG_W)'(c2_par_reg[i*REG_W +: REG_W])
                            * (2*REG_W)'(c2_am_reg);
        end
        m1_neg_reg <= c2_neg_reg;
        m1_nz_reg  <= c2_nz_reg;
        m1_par_reg <= c2_par_reg;
    end

    // Even limbs line up without overlap, odd limbs sit one limb higher.
    logic              m2_v_reg;
    logic [PROD_W-1:0] m2_prod_reg;
    logic              m2_neg_reg;
    logic              m2_nz_reg;
    logic [DIFF_W-1:0] m2_par_reg;
    logic [DIFF_W-1:0] pp_even;
    logic [DIFF_W-1:0] pp_odd;

    always_comb
    begin
        for (int i = 0; i < LIMBS / 2; i++)
        begin
            pp_even[i*2*REG_W +: 2*REG_W] = m1_pp_reg[2*i];
            pp_odd[i*2*REG_W +: 2*REG_W]  = m1_pp_reg[2*i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_v_reg <= 1'b0;
        end
        else
        begin
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_prod_reg <= {REG_W'(0), pp_even} + {pp_odd, REG_W'(0)};
        m2_neg_reg  <= m1_neg_reg;
        m2_nz_reg   <= m1_nz_reg;
        m2_par_reg  <= m1_par_reg;
    end

    // Second divider: scaled parent / quantization.
    logic              d2_v_reg   [DIV2_STEPS];
    logic [PROD_W-1:0] d2_num_reg [DIV2_STEPS];
    logic [REG_W-1:0]  d2_rem_reg [DIV2_STEPS];
    logic              d2_neg_reg [DIV2_STEPS];
    logic              d2_nz_reg  [DIV2_STEPS];
    logic [DIFF_W-1:0] d2_par_reg [DIV2_STEPS];

    for (genvar k = 0; k < DIV2_STEPS; k++)
    begin : g_div2
        logic              v_in;
        logic [PROD_W-1:0] num_in;
        logic [REG_W-1:0]  rem_in;
        logic              neg_in;
        logic              nz_in;
        logic [DIFF_W-1:0] par_in;
        logic [REG_W:0]    trial;
        logic [REG_W:0]    sub;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign v_in   = m2_v_reg;
            assign num_in = m2_prod_reg;
            assign rem_in = '0;
            assign neg_in = m2_neg_reg;
            assign nz_in  = m2_nz_reg;
            assign par_in = m2_par_reg;
        end
        else
        begin : g_rest
            assign v_in   = d2_v_reg[k-1];
            assign num_in = d2_num_reg[k-1];
            assign rem_in = d2_rem_reg[k-1];
            assign neg_in = d2_neg_reg[k-1];
            assign nz_in  = d2_nz_reg[k-1];
            assign par_in = d2_par_reg[k-1];
        end

        assign trial = {rem_in, num_in[PROD_W-1]};
        assign sub   = trial - {1'b0, qd_div};
        assign ge    = (trial >= {1'b0, qd_div});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d2_v_reg[k] <= 1'b0;
            end
            else
            begin
                d2_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            d2_rem_reg[k] <= ge ? sub[REG_W-1:0] : trial[REG_W-1:0];
            d2_num_reg[k] <= {num_in[PROD_W-2:0], ge};
            d2_neg_reg[k] <= neg_in;
            d2_nz_reg[k]  <= nz_in;
            d2_par_reg[k] <= par_in;
        end
    end

    // A zero delta with a nonzero adjustment becomes one.
    logic              f1_v_reg;
    logic [PROD_W-1:0] f1_del_reg;
    logic              f1_neg_reg;
    logic [DIFF_W-1:0] f1_par_reg;
    logic [PROD_W-1:0] quot;

    assign quot = d2_num_reg[DIV2_STEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= d2_v_reg[DIV2_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        f1_del_reg <= (quot == '0 && d2_nz_reg[DIV2_STEPS-1]) ? PROD_W'(1) : quot;
        f1_neg_reg <= d2_neg_reg[DIV2_STEPS-1];
        f1_par_reg <= d2_par_reg[DIV2_STEPS-1];
    end

    // Parent plus or minus delta on one adder.
    logic              f2_v_reg;
    logic [PROD_W:0]   f2_sum_reg;
    logic              f2_neg_reg;
    logic [PROD_W:0]   addend;

    assign addend = f1_neg_reg ? ~{1'b0, f1_del_reg} : {1'b0, f1_del_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_v_reg <= 1'b0;
        end
        else
        begin
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f2_sum_reg <= {(PROD_W+1-DIFF_W)'(0), f1_par_reg} + addend
                      + {{PROD_W{1'b0}}, f1_neg_reg};
        f2_neg_reg <= f1_neg_reg;
    end

    // Saturate above, clear on underflow, then apply the floor.
    logic              f3_v_reg;
    logic [DIFF_W-1:0] f3_res_reg;
    logic [DIFF_W-1:0] res_sat;
    logic [DIFF_W-1:0] res_next;

    always_comb
    begin
        if (f2_neg_reg)
        begin
            res_sat = f2_sum_reg[PROD_W] ? '0 : f2_sum_reg[DIFF_W-1:0];
        end
        else
        begin
            res_sat = (|f2_sum_reg[PROD_W:DIFF_W]) ? '1 : f2_sum_reg[DIFF_W-1:0];
        end
        res_next = (res_sat < DIFF_FLOOR) ? DIFF_FLOOR : res_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f3_v_reg <= 1'b0;
        end
        else
        begin
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f3_res_reg <= res_next;
    end

    assign done       = f3_v_reg;
    assign next_word0 = f3_res_reg[0*WORD_W +: WORD_W];
    assign next_word1 = f3_res_reg[1*WORD_W +: WORD_W];
    assign next_word2 = f3_res_reg[2*WORD_W +: WORD_W];
    assign next_word3 = f3_res_reg[3*WORD_W +: WORD_W];

    // Every result comes from a matching earlier transfer.
    `ASSERT_IMPLY(a_latency, clk, rst_n, done, $past(start, LAT), "result without matching transfer")
    // The clamped adjustment never falls below the lower limit.
    `ASSERT_IMPLY(a_clamp_lo, clk, rst_n, d1_v_reg[DIV1_STEPS-1], $signed(adj_next) >= $signed(adjust_min_reg), "adjustment below lower limit")
    // With ordered limits the adjustment also respects the upper limit.
    `ASSERT_IMPLY(a_clamp_hi, clk, rst_n, d1_v_reg[DIV1_STEPS-1] && ($signed(adjust_min_reg) <= $signed(adjust_max_reg)), $signed(adj_next) <= $signed(adjust_max_reg), "adjustment above upper limit")
    // A reported difficulty is never below the floor.
    `ASSERT_IMPLY(a_floor, clk, rst_n, done, !(next_word3 == '0 && next_word2 == '0 && next_word1 == '0 && next_word0 < 64'd2), "difficulty below floor")

endmodule

[bench/tb_difficulty_p_adjust.sv]
module tb_difficulty_p_adjust;
    import dpa_pkg::*;

    localparam int LATENCY     = 361;
    localparam int WATCH_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1600;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic [31:0]  measurement;
    logic [63:0]  parent_word0;
    logic [63:0]  parent_word1;
    logic [63:0]  parent_word2;
    logic [63:0]  parent_word3;
    logic         done;
    logic [63:0]  next_word0;
    logic [63:0]  next_word1;
    logic [63:0]  next_word2;
    logic [63:0]  next_word3;
    logic         cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;

    difficulty_p_adjust dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .measurement(measurement),
        .parent_word0(parent_word0), .parent_word1(parent_word1),
        .parent_word2(parent_word2), .parent_word3(parent_word3),
        .done(done),
        .next_word0(next_word0), .next_word1(next_word1),
        .next_word2(next_word2), .next_word3(next_word3),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Local copy of the adjustment registers.
    logic signed [31:0] m_gain;
    logic [31:0]        m_set_point;
    logic signed [31:0] m_adj_min;
    logic signed [31:0] m_adj_max;
    logic [31:0]        m_quant;

    logic [255:0] next_diff_q[$];
    int errors;
    int items_sent;
    int results_seen;
    int idle_cycles;

    // Directed table row; check_fixed marks rows with a hand-written answer.
    typedef struct {
        logic [31:0]  meas;
        logic [255:0] parent;
        bit           check_fixed;
        logic [255:0] fixed;
    } diff_row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Compute the new difficulty for one parent and measurement.
    function automatic logic [255:0] adjust_difficulty(logic [31:0] meas, logic [255:0] parent);
        logic signed [65:0] err;
        logic [65:0]        gmag;
        logic [65:0]        emag;
        logic [131:0]       quot;
        logic signed [65:0] adj;
        logic [65:0]        amag;
        logic [319:0]       delta;
        logic [319:0]       wide;
        logic [63:0]        sp;
        logic [63:0]        qd;
        bit                 neg;
        sp = (m_set_point == 0) ? 64'd1 : {32'd0, m_set_point};
        qd = (m_quant == 0) ? 64'd1 : {32'd0, m_quant};
        err = $signed({34'd0, m_set_point}) - $signed({34'd0, meas});
        gmag = m_gain < 0 ? 66'(-$signed({{34{m_gain[31]}}, m_gain}))
                          : {34'd0, m_gain};
        emag = err < 0 ? 66'(-err) : 66'(err);
        quot = ({66'd0, gmag} * {66'd0, emag}) / {68'd0, sp};
        neg = (m_gain < 0) != (err < 0);
        adj = neg ? -$signed(quot[65:0]) : $signed(quot[65:0]);
        if (adj > $signed({{34{m_adj_max[31]}}, m_adj_max}))
            adj = $signed({{34{m_adj_max[31]}}, m_adj_max});
        if (adj < $signed({{34{m_adj_min[31]}}, m_adj_min}))
            adj = $signed({{34{m_adj_min[31]}}, m_adj_min});
        amag = adj < 0 ? 66'(-adj) : 66'(adj);
        delta = ({64'd0, parent} * {254'd0, amag}) / {256'd0, qd};
        if (delta == 0 && adj != 0)
            delta = 320'd1;
        if (adj >= 0)
        begin
            wide = {64'd0, parent} + delta;
            if (wide[319:256] != 0)
                wide = {64'd0, {256{1'b1}}};
        end
        else if (delta >= {64'd0, parent})
            wide = 320'd0;
        else
            wide = {64'd0, parent} - delta;
        if (wide < 320'd2)
            wide = 320'd2;
        return wide[255:0];
    endfunction

    task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Every result is taken at the edge that ends its strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (next_diff_q.size() == 0)
                report_mismatch("unexpected result",
                                {next_word3, next_word2, next_word1, next_word0}, '0);
            else
            begin
                logic [255:0] want;
                want = next_diff_q.pop_front();
                if (next_word0 !== want[63:0])
                    report_mismatch("next_word0", {192'd0, next_word0}, {192'd0, want[63:0]});
                if (next_word1 !== want[127:64])
                    report_mismatch("next_word1", {192'd0, next_word1}, {192'd0, want[127:64]});
                if (next_word2 !== want[191:128])
                    report_mismatch("next_word2", {192'd0, next_word2}, {192'd0, want[191:128]});
                if (next_word3 !== want[255:192])
                    report_mismatch("next_word3", {192'd0, next_word3}, {192'd0, want[255:192]});
            end
        end
    end

    // Watchdog on cycles with no command, result or configuration transfer.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("watchdog expired");
            $display("difficulty_p_adjust test failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN:         m_gain = val;
            CFG_SET_POINT:    m_set_point = val;
            CFG_ADJUST_MIN:   m_adj_min = val;
            CFG_ADJUST_MAX:   m_adj_max = val;
            CFG_QUANTIZATION: m_quant = val;
            default: ;
        endcase
    endtask

    // Out-of-range index: the block must ignore it.
    task automatic write_bad_index(logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(5 + $urandom_range(0, 2));
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every outstanding result, then let the pipe run dry.
    task automatic drain;
        while (next_diff_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Present one item and hold it until it is taken.
    task automatic send_item(logic [31:0] meas, logic [255:0] parent, bit gaps);
        int gap;
        if (gaps)
        begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start        <= 1'b1;
        measurement  <= meas;
        parent_word0 <= parent[63:0];
        parent_word1 <= parent[127:64];
        parent_word2 <= parent[191:128];
        parent_word3 <= parent[255:192];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        next_diff_q.push_back(adjust_difficulty(meas, parent));
        items_sent++;
    endtask

    function automatic logic [255:0] rand_parent();
        logic [255:0] p;
        int shape;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        shape = $urandom_range(0, 9);
        if (shape == 0)
            p = p >> $urandom_range(200, 255);
        else if (shape == 1)
            p = ~(p >> $urandom_range(0, 20));
        else if (shape == 2)
            p = p >> $urandom_range(0, 255);
        return p;
    endfunction

    function automatic logic [31:0] rand_meas();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 3);
            default: return m_set_point + 32'($urandom_range(0, 400)) - 32'd200;
        endcase
    endfunction

    diff_row_t plan[];

    initial
    begin
        logic [255:0] ones;
        ones = {256{1'b1}};
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        measurement = '0;
        parent_word0 = '0;
        parent_word1 = '0;
        parent_word2 = '0;
        parent_word3 = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_gain = 5;
        m_set_point = 60;
        m_adj_min = -5;
        m_adj_max = 5;
        m_quant = 10;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under reset settings: floors, saturation, on-target.
        plan = '{
            '{32'd60, 256'd1000, 1'b1, 256'd1000},
            '{32'd0, 256'd0, 1'b1, 256'd2},
            '{32'd0, 256'd1, 1'b1, 256'd2},
            '{32'd0, 256'd100, 1'b1, 256'd150},
            '{32'hFFFF_FFFF, 256'd100, 1'b1, 256'd50},
            '{32'hFFFF_FFFF, 256'd3, 1'b1, 256'd2},
            '{32'd0, ones, 1'b1, ones},
            '{32'hFFFF_FFFF, ones, 1'b0, '0},
            '{32'd59, 256'd7, 1'b0, '0},
            '{32'd61, 256'd7, 1'b0, '0},
            '{32'd30, {4{64'hAAAA_5555_AAAA_5555}}, 1'b0, '0},
            '{32'd90, {4{64'h5555_AAAA_5555_AAAA}}, 1'b0, '0}
        };
        foreach (plan[i])
        begin
            send_item(plan[i].meas, plan[i].parent, 1'b0);
            if (plan[i].check_fixed)
                next_diff_q[$] = plan[i].fixed;
        end
        start <= 1'b0;
        drain();

        // Zero divisors and crossed clamp bounds.
        write_reg(CFG_SET_POINT, 32'd0);
        write_reg(CFG_QUANTIZATION, 32'd0);
        write_reg(CFG_ADJUST_MIN, 32'd3);
        write_reg(CFG_ADJUST_MAX, -32'sd3);
        write_bad_index(32'd0);
        send_item(32'd0, 256'd10, 1'b0);
        send_item(32'hFFFF_FFFF, 256'd10, 1'b0);
        start <= 1'b0;
        drain();

        // Widest limits with the most negative gain.
        write_reg(CFG_ADJUST_MIN, 32'h8000_0000);
        write_reg(CFG_ADJUST_MAX, 32'h7FFF_FFFF);
        write_reg(CFG_GAIN, 32'h8000_0000);
        send_item(32'd0, ones, 1'b0);
        send_item(32'hFFFF_FFFF, 256'd12345, 1'b0);
        start <= 1'b0;
        drain();

        // Random phases, each with fresh register settings.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(CFG_GAIN, 32'h7FFF_FFFF);
                write_reg(CFG_SET_POINT, 32'hFFFF_FFFF);
                write_reg(CFG_QUANTIZATION, 32'hFFFF_FFFF);
                write_reg(CFG_ADJUST_MIN, 32'h8000_0000);
                write_reg(CFG_ADJUST_MAX, 32'h7FFF_FFFF);
            end
            else
            begin
                write_reg(CFG_GAIN, ($urandom_range(0, 2) == 0) ? $urandom
                                    : 32'($signed($urandom_range(0, 40)) - 20));
                write_reg(CFG_SET_POINT, ($urandom_range(0, 2) == 0) ? $urandom
                                         : $urandom_range(0, 1000));
                write_reg(CFG_QUANTIZATION, ($urandom_range(0, 2) == 0) ? $urandom
                                            : $urandom_range(0, 100));
                write_reg(CFG_ADJUST_MIN, ($urandom_range(0, 2) == 0) ? $urandom
                                          : 32'(-$signed($urandom_range(0, 50))));
                write_reg(CFG_ADJUST_MAX, ($urandom_range(0, 2) == 0) ? $urandom
                                          : $urandom_range(0, 50));
            end
            for (int k = 0; k < RANDOM_ITEMS / 8; k++)
                send_item(rand_meas(), rand_parent(), 1'b1);
            start <= 1'b0;
            drain();
        end

        $display("Covered %0d transfers with %0d results over eleven register settings,",
                 items_sent, results_seen);
        $display("including zero divisors, crossed bounds, floor and saturation cases.");
        if (errors == 0 && next_diff_q.size() == 0)
            $display("difficulty_p_adjust test passed");
        else
            $display("difficulty_p_adjust test failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/dpa_pkg.sv
src/difficulty_p_adjust.sv
bench/tb_difficulty_p_adjust.sv
